// File: rtl/core/birs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// birs_pkg
// shared widths, result and queue status types, bound saturation helper
// ----------------------------------------------------------------------------
package birs_pkg;

   localparam int unsigned WordBits    = 16;
   localparam int unsigned IndexBits   = 10;
   localparam int unsigned CfgBits     = 11;
   localparam int unsigned RspDataBits = 16;
   localparam int unsigned NInUseReset = 1024;
   localparam int unsigned DefaultMaxN = 1024;
   localparam int unsigned QueueDepth  = 4;

   typedef struct packed {
      logic                 last;
      logic [IndexBits-1:0] sample_index;
   } result_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // zero reads as one, anything above the table size saturates
   function automatic int unsigned effective_n(input logic [CfgBits-1:0] n,
                                               input int unsigned max_n);
      int unsigned v;
      v = 32'(n);
      if (v == 0) begin
         v = 1;
      end
      if (v > max_n) begin
         v = max_n;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/bounded_index_rejection_sampler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_index_rejection_sampler_top
// bounded index sampler with rejection, 16-bit words, falling bound
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tdata[15:0] random_word
//  rsp_     out  rsp_tvalid/rsp_tready  tdata[9:0] sample_index, tlast last
//  csr_     in   csr_we                 csr_wdata[10:0] n_in_use
//
//  one word a cycle unless the queue is full: the front multiplies the
//  word by the bound, compares the low half against a prefetched threshold
//  and updates the bound in the same cycle; a hit is queued, then registered
//  reset (synchronous) loads n_in_use 1024, bound saturated to MAX_N
//  req_tready drops only when the four-entry queue is full
//  rsp stalls back up into the queue, not into the bound loop
//
module bounded_index_rejection_sampler_top #(
   parameter int unsigned MAX_N = birs_pkg::DefaultMaxN
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [birs_pkg::WordBits-1:0]      req_tdata,   // [15:0] random_word
   // response stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [birs_pkg::RspDataBits-1:0]        rsp_tdata,   // [9:0] sample_index, zero above
   output logic                                    rsp_tlast,   // last index of a sequence
   // control register
   input  wire logic                               csr_we,
   input  wire logic [birs_pkg::CfgBits-1:0]       csr_wdata    // [10:0] n_in_use
);
   import birs_pkg::*;

   // front to queue
   logic             push_valid;
   result_type       push_data;

   // queue to back
   queue_status_type q_status;
   result_type       q_data;
   logic             q_pop;

   // front: bound loop, threshold rom and multiplier
   birs_front #(
      .MAX_N (MAX_N)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decoupling queue, absorbs rsp back-pressure
   birs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (q_pop),
      .pop_data   (q_data),
      .status     (q_status)
   );

   // back: output register on the response stream
   birs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_data     (q_data),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: rtl/core/birs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// birs_front
// accepts random words, draws against the falling bound, pushes hits
// ----------------------------------------------------------------------------
module birs_front #(
   parameter int unsigned MAX_N = birs_pkg::DefaultMaxN
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [birs_pkg::WordBits-1:0]      req_tdata,
   input  wire logic                               csr_we,
   input  wire logic [birs_pkg::CfgBits-1:0]       csr_wdata,
   input  wire birs_pkg::queue_status_type         q_status,
   output logic                                    push_valid,
   output birs_pkg::result_type                    push_data
);
   import birs_pkg::*;

   localparam int unsigned BoundBits = $clog2(MAX_N + 1);
   localparam int unsigned ProdBits  = WordBits + BoundBits;
   localparam int unsigned ResetEff  = (NInUseReset > MAX_N) ? MAX_N : NInUseReset;
   localparam int unsigned ResetThrV = (2 ** WordBits) % ResetEff;
   localparam logic [WordBits-1:0]  ResetThr   = WordBits'(ResetThrV);
   localparam logic [BoundBits-1:0] ResetBound = BoundBits'(ResetEff);

   // threshold rom, entry s holds 2^16 mod s
   logic [WordBits-1:0] thr_rom [0:MAX_N];

   assign thr_rom[0] = '0;
   for (genvar s = 1; s <= MAX_N; s++) begin : g_rom
      localparam int unsigned ThrVal = (2 ** WordBits) % s;
      assign thr_rom[s] = WordBits'(ThrVal);
   end

   logic [BoundBits-1:0] bound_ff, bound_in;
   logic [BoundBits-1:0] eff_n_ff, eff_n_in;
   logic [WordBits-1:0]  thr_ff;
   logic [WordBits-1:0]  rel_thr_ff;
   logic [BoundBits-1:0] csr_eff;
   logic [BoundBits-1:0] bound_m1;
   logic [BoundBits-1:0] thr_addr;
   logic [BoundBits-1:0] rel_addr;
   logic                 thr_load;
   logic                 thr_from_rel;
   logic [ProdBits-1:0]  prod;
   logic                 take;
   logic                 hit;
   logic                 at_one;

   assign req_tready = !q_status.full;
   assign take       = req_tvalid && req_tready;
   assign csr_eff    = BoundBits'(effective_n(csr_wdata, MAX_N));
   assign bound_m1   = bound_ff - BoundBits'(1);
   assign at_one     = (bound_ff == BoundBits'(1));

   assign prod = ProdBits'(req_tdata) * ProdBits'(bound_ff);
   assign hit  = (prod[WordBits-1:0] >= thr_ff);

   assign push_valid             = take && hit;
   assign push_data.sample_index = IndexBits'(prod >> WordBits);
   assign push_data.last         = at_one;

   always_comb begin
      bound_in     = bound_ff;
      eff_n_in     = eff_n_ff;
      thr_load     = 1'b0;
      thr_from_rel = 1'b0;
      thr_addr     = bound_m1;
      rel_addr     = eff_n_ff;
      if (csr_we) begin
         eff_n_in = csr_eff;
         bound_in = csr_eff;
         thr_load = 1'b1;
         thr_addr = csr_eff;
         rel_addr = csr_eff;
      end else if (push_valid) begin
         thr_load = 1'b1;
         if (at_one) begin
            bound_in     = eff_n_ff;
            thr_from_rel = 1'b1;
         end else begin
            bound_in = bound_m1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff   <= ResetBound;
         eff_n_ff   <= ResetBound;
         thr_ff     <= ResetThr;
         rel_thr_ff <= ResetThr;
      end else begin
         bound_ff   <= bound_in;
         eff_n_ff   <= eff_n_in;
         rel_thr_ff <= thr_rom[rel_addr];
         if (thr_load) begin
            thr_ff <= thr_from_rel ? rel_thr_ff : thr_rom[thr_addr];
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/birs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// birs_queue
// short fifo of accepted indices between front and back
// ----------------------------------------------------------------------------
module birs_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   input  wire birs_pkg::result_type       push_data,
   input  wire logic                       pop,
   output birs_pkg::result_type            pop_data,
   output birs_pkg::queue_status_type      status
);
   import birs_pkg::*;

   localparam int unsigned PtrBits = $clog2(QueueDepth);
   localparam int unsigned CntBits = $clog2(QueueDepth + 1);
   localparam logic [PtrBits-1:0] LastSlot = PtrBits'(QueueDepth - 1);
   localparam logic [CntBits-1:0] FullCnt  = CntBits'(QueueDepth);

   result_type           mem [0:QueueDepth-1];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign status.full      = (count_ff == FullCnt);
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push_valid && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign pop_data         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/birs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// birs_back
// output register, drains the queue onto the result stream
// ----------------------------------------------------------------------------
module birs_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire birs_pkg::queue_status_type      q_status,
   input  wire birs_pkg::result_type            q_data,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [birs_pkg::RspDataBits-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);
   import birs_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign pop        = q_status.not_empty && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RspDataBits'(data_ff.sample_index);
   assign rsp_tlast  = data_ff.last;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= q_data;
      end
   end

endmodule
`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounded index rejection sampler: random words
// go in on req_, a cycle-level predictor with its own bound and sequence
// length works out the index and end-of-sequence flag for each word, and
// every rsp_ beat is compared in order against those predictions while both
// streams idle and stall at random
// ----------------------------------------------------------------------------
module tb;
   import birs_pkg::*;

   localparam int unsigned MaxN         = DefaultMaxN;
   localparam int unsigned CycleLimit   = 200000;
   // a hit passes the queue and the output register on its way to rsp
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned ReportLimit  = 60;
   localparam int unsigned RandPhases   = 12;
   localparam int unsigned PhaseWords   = 120;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [WordBits-1:0]    req_tdata;   // [15:0] random_word
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RspDataBits-1:0] rsp_tdata;   // [9:0] sample_index, zero above
   logic                   rsp_tlast;   // last index of a sequence
   logic                   csr_we;
   logic [CfgBits-1:0]     csr_wdata;   // [10:0] n_in_use

   // words waiting for the driver, indices waiting for the block
   logic [WordBits-1:0] word_queue[$];
   result_type          index_queue[$];

   // predictor state
   logic [CfgBits-1:0]  seq_len_reg;
   logic [CfgBits-1:0]  draw_bound;

   logic                req_beat;
   int unsigned         send_idle_pct;
   int unsigned         recv_idle_pct;
   int unsigned         cycle_count;
   int unsigned         words_issued;
   int unsigned         word_beats;
   int unsigned         index_beats;
   int unsigned         rejected_words;
   int unsigned         sequence_ends;
   int unsigned         csr_writes;
   int unsigned         mismatches;

   bounded_index_rejection_sampler_top #(
      .MAX_N(MaxN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // zero means a sequence of one, anything past the table saturates
   function automatic logic [CfgBits-1:0] clamp_seq_len(input logic [CfgBits-1:0] n);
      if (n == '0) begin
         return CfgBits'(1);
      end
      if (n > CfgBits'(MaxN)) begin
         return CfgBits'(MaxN);
      end
      return n;
   endfunction

   // mostly uniform words, with a share of zeros, all-ones and tiny values
   // so that words falling under the threshold turn up often
   function automatic logic [WordBits-1:0] pick_word();
      int unsigned sel;
      sel = $urandom_range(19);
      case (sel)
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         2, 3: begin
            return WordBits'($urandom_range(63));
         end
         default: begin
            return WordBits'($urandom_range(65535));
         end
      endcase
   endfunction

   // sequence lengths: short ones so that sequence ends are frequent, plus
   // the full table, zero, one and values past the table
   function automatic logic [CfgBits-1:0] pick_seq_len(input int unsigned phase);
      case (phase % 6)
         0: begin
            return CfgBits'(MaxN);
         end
         1: begin
            return CfgBits'($urandom_range(2, 12));
         end
         2: begin
            return CfgBits'($urandom_range(13, 200));
         end
         3: begin
            return CfgBits'($urandom_range(1, 2047));
         end
         4: begin
            return CfgBits'($urandom_range(1));
         end
         default: begin
            return CfgBits'($urandom_range(1000, 2047));
         end
      endcase
   endfunction

   task automatic push_word(input logic [WordBits-1:0] w);
      word_queue.push_back(w);
      words_issued++;
   endtask

   task automatic write_seq_len(input logic [CfgBits-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // every word accepted, every index back, then let any rejected word
   // still in the pipe clear out
   task automatic wait_for_drain();
      @(negedge clock);
      while (word_beats != words_issued || index_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_idling(input int unsigned mode);
      case (mode)
         0: begin
            send_idle_pct = 38;
            recv_idle_pct = 76;
         end
         1: begin
            send_idle_pct = 76;
            recv_idle_pct = 38;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   // driver: new beat at the falling edge once the previous one has gone,
   // receiver stalls drawn each cycle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_beat) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= word_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // predictor and checker, all on the rising edge
   always @(posedge clock) begin : monitor
      logic [31:0]    product;
      logic [16:0]    threshold;
      result_type     drawn;
      result_type     want;

      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: cycle limit reached, %0d of %0d words accepted, %0d indices owed",
                  $time, word_beats, words_issued, index_queue.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         req_beat <= req_tvalid && req_tready && !reset;
         if (reset) begin
            seq_len_reg = CfgBits'(NInUseReset);
            draw_bound  = clamp_seq_len(seq_len_reg);
         end else begin
            // a write restarts whatever sequence was in progress
            if (csr_we) begin
               seq_len_reg = csr_wdata;
               draw_bound  = clamp_seq_len(csr_wdata);
               csr_writes++;
            end

            if (req_tvalid && req_tready) begin
               word_beats++;
               product   = 32'(req_tdata) * 32'(draw_bound);
               threshold = 17'(32'h10000 % 32'(draw_bound));
               if (17'(product[WordBits-1:0]) < threshold) begin
                  // word rejected, bound untouched
                  rejected_words++;
               end else begin
                  drawn.sample_index = product[WordBits+IndexBits-1:WordBits];
                  drawn.last         = (draw_bound == CfgBits'(1));
                  index_queue.push_back(drawn);
                  if (drawn.last) begin
                     sequence_ends++;
                     draw_bound = clamp_seq_len(seq_len_reg);
                  end else begin
                     draw_bound = draw_bound - CfgBits'(1);
                  end
               end
            end

            if (rsp_tvalid && rsp_tready) begin
               index_beats++;
               if (index_queue.size() == 0) begin
                  mismatches++;
                  if (mismatches <= ReportLimit) begin
                     $display("%0t: index beat with nothing owed: expected none, actual %0d last %0b",
                              $time, rsp_tdata, rsp_tlast);
                  end
               end else begin
                  want = index_queue.pop_front();
                  if (rsp_tdata !== RspDataBits'(want.sample_index)) begin
                     mismatches++;
                     if (mismatches <= ReportLimit) begin
                        $display("%0t: sample_index mismatch: expected %0d, actual %0d",
                                 $time, want.sample_index, rsp_tdata);
                     end
                  end
                  if (rsp_tlast !== want.last) begin
                     mismatches++;
                     if (mismatches <= ReportLimit) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, rsp_tlast);
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_beat       = 1'b0;
      cycle_count    = 0;
      words_issued   = 0;
      word_beats     = 0;
      index_beats    = 0;
      rejected_words = 0;
      sequence_ends  = 0;
      csr_writes     = 0;
      mismatches     = 0;
      set_idling(0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset length of 1024, a power of two so the first word is not rejected
      push_word(16'h0000);
      push_word(16'hFFFF);
      push_word(16'h8000);
      push_word(16'h0001);
      push_word(16'hAAAA);
      push_word(16'h5555);
      wait_for_drain();

      // zero length reads as one: every word ends a sequence with index 0
      write_seq_len(CfgBits'(0));
      push_word(16'hFFFF);
      push_word(16'h1234);
      push_word(16'h0000);
      wait_for_drain();

      // all ones saturates to the table size
      write_seq_len('1);
      push_word(16'hFFFF);
      push_word(16'h0000);
      wait_for_drain();

      // bound one, threshold zero
      write_seq_len(CfgBits'(1));
      push_word(16'h7FFF);
      wait_for_drain();

      // length three: zero word is rejected at bound three, then a full run
      write_seq_len(CfgBits'(3));
      push_word(16'h0000);
      push_word(16'hFFFF);
      push_word(16'h5555);
      push_word(16'hAAAA);
      push_word(16'h0001);
      wait_for_drain();

      // odd bound just below the top, with words either side of the threshold
      write_seq_len(CfgBits'(1023));
      push_word(16'h0000);
      push_word(16'hFFFF);
      push_word(16'h0040);
      wait_for_drain();

      // random phases: heavy idling on the receiver, then on the sender, then none
      for (int unsigned p = 0; p < RandPhases; p++) begin
         set_idling(p / 4);
         // one phase carries on mid-sequence without a fresh length
         if (p != 8) begin
            write_seq_len(pick_seq_len(p));
         end
         for (int unsigned i = 0; i < PhaseWords; i++) begin
            push_word(pick_word());
            // hold the sender once until every index is back
            if (p == 5 && i == PhaseWords / 2) begin
               wait_for_drain();
            end
         end
         wait_for_drain();
      end

      $display("run covered %0d words, %0d indices checked, %0d words rejected",
               word_beats, index_beats, rejected_words);
      $display("%0d sequences completed across %0d length register writes",
               sequence_ends, csr_writes);
      if (mismatches == 0 && index_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
